// File: rtl/ppg_pkg.sv
// Shared constants, types and constant tables for the plasma pixel generator.
`default_nettype none

package ppg_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;
  localparam int unsigned TableSize = 256;

  localparam int unsigned CoordW = 10;
  localparam int unsigned SizeW  = 11;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned ColorW = 16;

  // Configuration register indexes.
  localparam logic [1:0] RegFrameWidth  = 2'd0;
  localparam logic [1:0] RegFrameHeight = 2'd1;

  localparam logic [SizeW-1:0] FrameWidthReset  = 11'd320;
  localparam logic [SizeW-1:0] FrameHeightReset = 11'd240;

  typedef logic [TableSize-1:0][7:0]        sine_tab_t;
  typedef logic [TableSize-1:0][ColorW-1:0] pal_tab_t;

  typedef logic [64:0][7:0] quarter_t;

  // First quarter of the sine wave, amplitude 127, entry 0 in the lowest slot.
  localparam quarter_t SineQuarter = {
    8'd127, 8'd126, 8'd126, 8'd126, 8'd126, 8'd126, 8'd125, 8'd125, 8'd124, 8'd123,
    8'd123, 8'd122, 8'd121, 8'd120, 8'd119, 8'd118, 8'd117, 8'd116, 8'd114, 8'd113,
    8'd112, 8'd110, 8'd108, 8'd107, 8'd105, 8'd103, 8'd102, 8'd100, 8'd98,  8'd96,
    8'd94,  8'd91,  8'd89,  8'd87,  8'd85,  8'd82,  8'd80,  8'd78,  8'd75,  8'd73,
    8'd70,  8'd67,  8'd65,  8'd62,  8'd59,  8'd57,  8'd54,  8'd51,  8'd48,  8'd45,
    8'd42,  8'd39,  8'd36,  8'd33,  8'd30,  8'd27,  8'd24,  8'd21,  8'd18,  8'd15,
    8'd12,  8'd9,   8'd6,   8'd3,   8'd0
  };

  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    int        q;
    int        m;
    logic [7:0] v;
    for (int i = 0; i < TableSize; i++) begin
      q = i % 128;
      m = (q <= 64) ? q : 128 - q;
      v = SineQuarter[m];
      tab[i] = (i < 128) ? v : 8'(-v);
    end
    return tab;
  endfunction

  function automatic int blend(int a, int b, int k);
    int d;
    d = (b - a) * k;
    return (a + d / 127) % 256;
  endfunction

  function automatic pal_tab_t build_palette();
    pal_tab_t   tab;
    int         k;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    for (int i = 0; i < TableSize; i++) begin
      if (i < 128) begin
        k = i;
        r = 8'(blend(18, 70, k));
        g = 8'(blend(30, 20, k));
        b = 8'(blend(110, 105, k));
      end else begin
        k = i - 128;
        r = 8'(blend(70, 130, k));
        g = 8'(blend(20, 20, k));
        b = 8'(blend(105, 35, k));
      end
      tab[i] = {r[7:3], g[7:2], b[7:3]};
    end
    return tab;
  endfunction

  localparam sine_tab_t SineRom    = build_sine();
  localparam pal_tab_t  PaletteRom = build_palette();

endpackage

`default_nettype wire

// File: rtl/plasma_pattern_pixel_generator_core.sv
// Top level of the plasma pixel generator: raster counters, ROM pipeline, output stage.
`default_nettype none

// Plasma pattern pixel generator.
// Every transfer on the slave stream whose step bit is 1 produces the next pixel of the
// frame in raster order on the master stream; a transfer with step 0 is consumed and
// produces nothing. The master tdata carries column, row and RGB565 color, tlast marks
// the last pixel of a row and tuser the last pixel of a frame.
// The frame size registers are written through the cfg channel, which is always ready;
// sizes of 0 act as 1 and sizes above 1024 act as 1024. Writes leave the counters alone.
// A pixel goes through three register stages: the sine ROM reads, the palette index
// multiply, and the palette ROM read into the output register, which drives the master
// side; one pixel per cycle is sustained while the master side is ready.
// The stages only hold while the stage after them is full and stalled, so requests keep
// being accepted while the output waits, until every stage is occupied.
// Reset clears the counters, the phase and all stage valids and restores the sizes to
// 320 by 240; the first frame after reset uses phase 1.
module plasma_pattern_pixel_generator_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Request stream. tdata: [0] step, [7:1] zero.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  // Pixel stream. tdata: [9:0] pixel_x, [19:10] pixel_y, [35:20] color, [39:36] zero.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,
  output logic             m_axis_tlast,  // end_of_line
  output logic             m_axis_tuser,  // end_of_frame
  // Configuration writes.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [10:0] cfg_data_i
);

  localparam int unsigned CW = ppg_pkg::CoordW;
  localparam int unsigned SW = ppg_pkg::SizeW;
  localparam int unsigned IW = ppg_pkg::IdxW;

  logic [SW-1:0] width_q, height_q;
  logic [SW-1:0] width_eff, height_eff;

  logic [CW-1:0] col_q, col_d, row_q, row_d;
  logic [IW-1:0] phase_q, phase_d;

  logic          ld1, ld2, ld3;
  logic          v1_q, v2_q, v3_q;
  logic          eol0, eof0;
  logic [IW-1:0] idx_a, idx_b, idx_c;

  logic [CW-1:0] x1_q, y1_q, x2_q, y2_q, x3_q, y3_q;
  logic          eol1_q, eof1_q, eol2_q, eof2_q, eol3_q, eof3_q;
  logic signed [7:0] sa_q, sb_q, sc_q;
  logic [IW-1:0] cidx_q;
  logic [ppg_pkg::ColorW-1:0] color_q;

  logic signed [SW-1:0] sum_s;
  logic [16:0]          prod;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ppg_pkg::FrameWidthReset;
      height_q <= ppg_pkg::FrameHeightReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ppg_pkg::RegFrameWidth:  width_q  <= cfg_data_i;
        ppg_pkg::RegFrameHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      width_eff = SW'(1);
    end else if (width_q > SW'(ppg_pkg::MaxWidth)) begin
      width_eff = SW'(ppg_pkg::MaxWidth);
    end else begin
      width_eff = width_q;
    end
    if (height_q == '0) begin
      height_eff = SW'(1);
    end else if (height_q > SW'(ppg_pkg::MaxHeight)) begin
      height_eff = SW'(ppg_pkg::MaxHeight);
    end else begin
      height_eff = height_q;
    end
  end

  // Stage handshakes: a stage loads when the one after it is empty or moving on.
  assign ld3           = v2_q & (~v3_q | m_axis_tready);
  assign ld2           = v1_q & (~v2_q | ld3);
  assign s_axis_tready = ~v1_q | ld2;
  assign ld1           = s_axis_tvalid & s_axis_tready & s_axis_tdata[0];

  // Raster position and ROM addresses for the pixel being requested.
  always_comb begin
    phase_d = phase_q;
    if (col_q == '0 && row_q == '0) begin
      phase_d = phase_q + IW'(1);
    end
    eol0 = ({1'b0, col_q} + SW'(1)) >= width_eff;
    eof0 = eol0 & (({1'b0, row_q} + SW'(1)) >= height_eff);
    if (eol0) begin
      col_d = '0;
      row_d = eof0 ? '0 : row_q + CW'(1);
    end else begin
      col_d = col_q + CW'(1);
      row_d = row_q;
    end
    idx_a = IW'(3) * col_q[IW-1:0] + {phase_d[IW-2:0], 1'b0};
    idx_b = {row_q[IW-3:0], 2'b00} + IW'(3) * phase_d;
    idx_c = {col_q[IW-2:0], 1'b0} + {row_q[IW-2:0], 1'b0} + phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      phase_q <= '0;
    end else if (ld1) begin
      col_q   <= col_d;
      row_q   <= row_d;
      phase_q <= phase_d;
    end
  end

  // Stage valids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ld1) begin
        v1_q <= 1'b1;
      end else if (ld2) begin
        v1_q <= 1'b0;
      end
      if (ld2) begin
        v2_q <= 1'b1;
      end else if (ld3) begin
        v2_q <= 1'b0;
      end
      if (ld3) begin
        v3_q <= 1'b1;
      end else if (m_axis_tready) begin
        v3_q <= 1'b0;
      end
    end
  end

  // Stage 1: three synchronous sine ROM reads.
  always_ff @(posedge clk_i) begin
    if (ld1) begin
      sa_q   <= ppg_pkg::SineRom[idx_a];
      sb_q   <= ppg_pkg::SineRom[idx_b];
      sc_q   <= ppg_pkg::SineRom[idx_c];
      x1_q   <= col_q;
      y1_q   <= row_q;
      eol1_q <= eol0;
      eof1_q <= eof0;
    end
  end

  // Stage 2: the biased sum of the sines is at least 3, so it fits ten unsigned bits.
  assign sum_s = SW'(sa_q) + SW'(sb_q) + SW'(sc_q) + SW'(384);
  assign prod  = 17'(sum_s[SW-2:0]) * 17'd85;

  always_ff @(posedge clk_i) begin
    if (ld2) begin
      cidx_q <= prod[15:8];
      x2_q   <= x1_q;
      y2_q   <= y1_q;
      eol2_q <= eol1_q;
      eof2_q <= eof1_q;
    end
  end

  // Stage 3: synchronous palette ROM read into the output register.
  always_ff @(posedge clk_i) begin
    if (ld3) begin
      color_q <= ppg_pkg::PaletteRom[cidx_q];
      x3_q    <= x2_q;
      y3_q    <= y2_q;
      eol3_q  <= eol2_q;
      eof3_q  <= eof2_q;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {4'b0000, color_q, y3_q, x3_q};
  assign m_axis_tlast  = eol3_q;
  assign m_axis_tuser  = eof3_q;

endmodule

`default_nettype wire

// File: dv/plasma_pattern_pixel_generator_core_tb.sv
// Self-checking testbench for the plasma pattern pixel generator core.
module plasma_pattern_pixel_generator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Indexes past the register list; writes to them must be ignored.
  localparam logic [1:0] RegSpare2 = 2'd2;
  localparam logic [1:0] RegSpare3 = 2'd3;
  localparam int PipeDepth = 3;
  localparam int RandomSteps = 210;

  typedef struct packed {
    logic [ppg_pkg::CoordW-1:0] x;
    logic [ppg_pkg::CoordW-1:0] y;
    logic [ppg_pkg::ColorW-1:0] color;
    logic                       eol;
    logic                       eof;
  } pixel_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [7:0]                s_axis_tdata = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [39:0]               m_axis_tdata;
  logic                      m_axis_tlast;
  logic                      m_axis_tuser;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [1:0]                cfg_index_i = '0;
  logic [ppg_pkg::SizeW-1:0] cfg_data_i = '0;

  plasma_pattern_pixel_generator_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("plasma_pattern_pixel_generator_core_tb failed");
    $finish;
  end

  // Generator state as the pixel predictor sees it.
  logic [ppg_pkg::SizeW-1:0] width_reg = ppg_pkg::FrameWidthReset;
  logic [ppg_pkg::SizeW-1:0] height_reg = ppg_pkg::FrameHeightReset;
  int               col = 0;
  int               row = 0;
  logic [7:0]       phase = '0;
  int               sine_lut [ppg_pkg::TableSize];
  logic [15:0]      palette_lut [ppg_pkg::TableSize];

  const int sine_quarter [65] = '{
      0,   3,   6,   9,  12,  15,  18,  21,  24,  27,  30,  33,  36,
     39,  42,  45,  48,  51,  54,  57,  59,  62,  65,  67,  70,  73,
     75,  78,  80,  82,  85,  87,  89,  91,  94,  96,  98, 100, 102,
    103, 105, 107, 108, 110, 112, 113, 114, 116, 117, 118, 119, 120,
    121, 122, 123, 123, 124, 125, 125, 126, 126, 126, 126, 126, 127};
  const int hue [3][3] = '{'{18, 30, 110}, '{70, 20, 105}, '{130, 20, 35}};

  pixel_t pending_pixels [$];
  bit     no_gaps = 1'b0;
  int     mismatches = 0;
  int     pixels_checked = 0;
  int     steps_sent = 0;
  int     idle_sent = 0;
  int     reg_writes = 0;

  function automatic int clamp_size(int v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Computes the pixel that the next step request yields and advances the raster.
  function automatic pixel_t next_plasma_pixel();
    pixel_t px;
    int     w;
    int     h;
    int     ph;
    int     i1;
    int     i2;
    int     i3;
    int     s;
    int     ci;
    w = clamp_size(int'(width_reg), int'(ppg_pkg::MaxWidth));
    h = clamp_size(int'(height_reg), int'(ppg_pkg::MaxHeight));
    if (col == 0 && row == 0) phase = phase + 8'd1;
    ph = int'(phase);
    i1 = (3 * col + 2 * ph) & 255;
    i2 = (4 * row + 3 * ph) & 255;
    i3 = (2 * col + 2 * row + ph) & 255;
    s  = sine_lut[i1] + sine_lut[i2] + sine_lut[i3] + 384;
    ci = ((s * 85) >> 8) & 255;
    px.x     = ppg_pkg::CoordW'(col);
    px.y     = ppg_pkg::CoordW'(row);
    px.color = palette_lut[ci];
    px.eol   = (col + 1 >= w);
    px.eof   = px.eol && (row + 1 >= h);
    if (px.eol) begin
      col = 0;
      row = px.eof ? 0 : row + 1;
    end else begin
      col = col + 1;
    end
    return px;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Pixel stream sink: random back-pressure and comparison against the oldest prediction.
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, expected none actual x=%0d y=%0d", $time,
                 m_axis_tdata[9:0], m_axis_tdata[19:10]);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_x", want.x, m_axis_tdata[9:0]);
        check_field("pixel_y", want.y, m_axis_tdata[19:10]);
        check_field("color", want.color, m_axis_tdata[35:20]);
        check_field("end_of_line", want.eol, m_axis_tlast);
        check_field("end_of_frame", want.eof, m_axis_tuser);
        pixels_checked++;
      end
    end
    m_axis_tready <= no_gaps || ($urandom_range(99) >= 9);
  end

  task automatic send_request(input logic step);
    while (!no_gaps && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, step};
    do @(posedge clk_i); while (!s_axis_tready);
    if (step) begin
      pending_pixels.push_back(next_plasma_pixel());
      steps_sent++;
    end else begin
      idle_sent++;
    end
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
  endtask

  // Valid stays high across back-to-back writes; the last one of a batch lowers it.
  task automatic write_reg(input logic [1:0] idx, input logic [ppg_pkg::SizeW-1:0] val,
                           input bit last_one);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == ppg_pkg::RegFrameWidth) width_reg = val;
    else if (idx == ppg_pkg::RegFrameHeight) height_reg = val;
    reg_writes++;
    if (last_one) cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 2) @(posedge clk_i);
  endtask

  task automatic burst_steps(input int n);
    repeat (n) send_request(1'b1);
    end_burst();
  endtask

  // Reset sizes; the first pixel after reset runs with phase 1.
  task automatic test_reset_sizes();
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b1);
    end_burst();
    drain();
  endtask

  // Zero sizes act as one pixel, so every pixel closes a frame; then a 3x2 frame wraps.
  task automatic test_tiny_frames();
    write_reg(ppg_pkg::RegFrameWidth, '0, 1'b0);
    write_reg(ppg_pkg::RegFrameHeight, '0, 1'b1);
    send_request(1'b1);
    send_request(1'b0);
    burst_steps(2);
    drain();
    write_reg(ppg_pkg::RegFrameWidth, 11'd3, 1'b0);
    write_reg(ppg_pkg::RegFrameHeight, 11'd2, 1'b1);
    burst_steps(7);
    drain();
  endtask

  // Shrinking below the current position ends the line and the frame at once.
  task automatic test_mid_frame_shrink();
    write_reg(ppg_pkg::RegFrameWidth, 11'd8, 1'b0);
    write_reg(ppg_pkg::RegFrameHeight, 11'd4, 1'b1);
    burst_steps(5);
    drain();
    write_reg(RegSpare2, 11'd1, 1'b0);
    write_reg(ppg_pkg::RegFrameWidth, 11'd3, 1'b0);
    write_reg(ppg_pkg::RegFrameHeight, 11'd1, 1'b1);
    burst_steps(3);
    drain();
  endtask

  // Over-range sizes act as the maximum; a full-width row runs with no idling at all.
  task automatic test_extreme_sizes();
    write_reg(RegSpare3, 11'h7FF, 1'b0);
    write_reg(ppg_pkg::RegFrameWidth, 11'd2047, 1'b0);
    write_reg(ppg_pkg::RegFrameHeight, 11'd2047, 1'b1);
    no_gaps = 1'b1;
    burst_steps(int'(ppg_pkg::MaxWidth));
    drain();
    no_gaps = 1'b0;
  endtask

  function automatic logic [ppg_pkg::SizeW-1:0] pick_size();
    case ($urandom_range(9))
      0: return '0;
      1: return 11'd1;
      2: return 11'd2;
      3: return 11'd1024;
      4: return ppg_pkg::SizeW'($urandom_range(1025, 2047));
      5: return 11'd2047;
      6: return ppg_pkg::SizeW'($urandom_range(2047));
      default: return ppg_pkg::SizeW'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic test_random_traffic();
    int   done_steps;
    int   n;
    logic step;
    done_steps = 0;
    while (done_steps < RandomSteps) begin
      if ($urandom_range(3) != 0) begin
        if ($urandom_range(2) == 0) begin
          write_reg($urandom_range(1) ? RegSpare3 : RegSpare2,
                    ppg_pkg::SizeW'($urandom_range(2047)), 1'b0);
        end
        write_reg(ppg_pkg::RegFrameWidth, pick_size(), 1'b0);
        write_reg(ppg_pkg::RegFrameHeight, pick_size(), 1'b1);
      end
      n = $urandom_range(5, 25);
      repeat (n) begin
        step = ($urandom_range(99) < 85);
        send_request(step);
        if (step) done_steps++;
      end
      end_burst();
      drain();
    end
  endtask

  initial begin : main
    int k;
    int seg;
    int q;
    int m;
    int r;
    int g;
    int b;
    for (int i = 0; i < ppg_pkg::TableSize; i++) begin
      q = i & 127;
      m = (q <= 64) ? q : 128 - q;
      sine_lut[i] = (i < 128) ? sine_quarter[m] : -sine_quarter[m];
      seg = i / 128;
      k = i % 128;
      r = hue[seg][0] + ((hue[seg + 1][0] - hue[seg][0]) * k) / 127;
      g = hue[seg][1] + ((hue[seg + 1][1] - hue[seg][1]) * k) / 127;
      b = hue[seg][2] + ((hue[seg + 1][2] - hue[seg][2]) * k) / 127;
      palette_lut[i] = 16'(((r & 'hF8) << 8) | ((g & 'hFC) << 3) | (b >> 3));
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_sizes();
    test_tiny_frames();
    test_mid_frame_shrink();
    test_extreme_sizes();
    test_random_traffic();
    drain();

    $display("Sent %0d pixel requests and %0d empty requests over %0d register writes.",
             steps_sent, idle_sent, reg_writes);
    $display("Checked %0d pixels, including a clamped full-width row, tiny frames and shrinks.",
             pixels_checked);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("plasma_pattern_pixel_generator_core_tb passed");
    end else begin
      $display("plasma_pattern_pixel_generator_core_tb failed");
    end
    $finish;
  end

endmodule
